### design/assert_macros.svh
// Assertion macros for the checker file of the free list manager.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a boolean condition holds on every clock edge outside reset.
`define IFL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define IFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ifl_pkg.sv
// Package of the indexed free list manager: field widths, operation codes
// and controller state encoding. It depends on nothing else.
package ifl_pkg;

  localparam int POOL_SLOTS_DEF = 1024;

  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 10;
  localparam int RCNT_W     = 11;
  localparam int LCNT_W     = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_POP   = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_POP   = 3'b100
  } state_t;

endpackage

### design/indexed_free_list_manager.sv
// Indexed free list manager: a LIFO list of free pool slots kept in a
// link memory with a head register and a saturating count.
// Depends on ifl_pkg.
//
// The input channel (in_) carries one operation per item: push one slot,
// push a run of consecutive slots, pop the head slot, or no-op. Every
// item gives exactly one result item on the out_ channel with the popped
// slot, the found and range error flags, and the list count after it.
// A push, a range push, a no-op or a pop on an empty list loads the result
// register in the cycle after acceptance. A pop of a listed slot first goes to
// S_POP: the link of the head slot is read from the synchronous link memory,
// and in S_POP the new head is formed from that read data and the result is
// registered. Only one item is in flight; the next is taken in the cycle the
// result register is loaded or freed, so pushes sustain one item per cycle
// while results are taken; a pop holds off the next item while in S_POP.
// After reset the link memory is cleared one entry per cycle, in state
// S_CLEAR; in_tready stays low during that pass.
// When the receiver stalls, the result is held in the output register and
// in_tready drops until the result is taken.
module indexed_free_list_manager #(
  parameter int POOL_SLOTS = ifl_pkg::POOL_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: slot_index[9:0], range_count[20:10], zero fill.
  input  logic [ifl_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [ifl_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: popped_slot[9:0], list_count[20:10], zero fill.
  output logic [ifl_pkg::OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0: found[0], range_error[1].
  output logic [ifl_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int IW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int HW  = $clog2(POOL_SLOTS + 1);
  localparam int LW  = $clog2(POOL_SLOTS + 2);
  localparam int SW  = (HW > 12) ? HW + 1 : 13;
  localparam int PAD = ifl_pkg::OUT_DATA_W - ifl_pkg::SLOT_W - ifl_pkg::LCNT_W;

  ifl_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   clr_idx_r, clr_idx_nxt;
  logic [HW-1:0]   head_r, head_nxt;
  logic [HW-1:0]   count_r, count_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ifl_pkg::SLOT_W-1:0]  out_popped_r, out_popped_nxt;
  logic                        out_found_r, out_found_nxt;
  logic                        out_err_r, out_err_nxt;
  logic [ifl_pkg::LCNT_W-1:0]  out_count_r, out_count_nxt;

  logic [LW-1:0] link_mem [POOL_SLOTS];
  logic [LW-1:0] rdata_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic          mem_re;

  ifl_pkg::mode_t             in_mode;
  logic [ifl_pkg::SLOT_W-1:0] in_slot;
  logic [ifl_pkg::RCNT_W-1:0] in_rcnt;
  logic                       in_fire;
  logic                       out_free;

  logic [SW-1:0] slot_x, rcnt_x, pool_x, head_x, count_x, end_x, last_x;
  logic [SW-1:0] add_n, sum_x, sat_x, dec_x, link_x, succ_x, clamp_x;
  logic          push_err, range_err;

  assign in_mode = ifl_pkg::mode_t'(in_tuser[ifl_pkg::MODE_W-1:0]);
  assign in_slot = in_tdata[ifl_pkg::SLOT_W-1:0];
  assign in_rcnt = in_tdata[ifl_pkg::SLOT_W +: ifl_pkg::RCNT_W];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ifl_pkg::S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign slot_x  = SW'(in_slot);
  assign rcnt_x  = SW'(in_rcnt);
  assign pool_x  = SW'(POOL_SLOTS);
  assign head_x  = SW'(head_r);
  assign count_x = SW'(count_r);
  assign end_x   = slot_x + rcnt_x;
  assign last_x  = end_x - SW'(1);

  assign push_err  = slot_x >= pool_x;
  assign range_err = (in_rcnt == '0) || (end_x > pool_x);

  assign add_n = (in_mode == ifl_pkg::MODE_RANGE) ? rcnt_x : SW'(1);
  assign sum_x = count_x + add_n;
  assign sat_x = (sum_x >= pool_x) ? pool_x : sum_x;
  assign dec_x = (count_x != '0) ? count_x - SW'(1) : count_x;

  assign link_x  = SW'(rdata_r);
  assign succ_x  = (rdata_r != '0) ? link_x - SW'(1) : head_x + SW'(1);
  assign clamp_x = (succ_x > pool_x) ? pool_x : succ_x;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_popped_nxt = out_popped_r;
    out_found_nxt  = out_found_r;
    out_err_nxt    = out_err_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;

    unique case (state_r)
      ifl_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + IW'(1);
        if (clr_idx_r == IW'(POOL_SLOTS - 1)) begin
          state_nxt = ifl_pkg::S_IDLE;
        end
      end
      ifl_pkg::S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_found_nxt  = 1'b0;
          out_err_nxt    = 1'b0;
          out_count_nxt  = count_x[ifl_pkg::LCNT_W-1:0];
          unique case (in_mode)
            ifl_pkg::MODE_PUSH: begin
              if (push_err) begin
                out_err_nxt = 1'b1;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = slot_x[IW-1:0];
                mem_wdata     = LW'(head_r) + LW'(1);
                head_nxt      = slot_x[HW-1:0];
                count_nxt     = sat_x[HW-1:0];
                out_count_nxt = sat_x[ifl_pkg::LCNT_W-1:0];
              end
            end
            ifl_pkg::MODE_RANGE: begin
              if (range_err) begin
                out_err_nxt = 1'b1;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = last_x[IW-1:0];
                mem_wdata     = LW'(head_r) + LW'(1);
                head_nxt      = slot_x[HW-1:0];
                count_nxt     = sat_x[HW-1:0];
                out_count_nxt = sat_x[ifl_pkg::LCNT_W-1:0];
              end
            end
            ifl_pkg::MODE_POP: begin
              if (head_x < pool_x) begin
                mem_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = ifl_pkg::S_POP;
              end
            end
            ifl_pkg::MODE_NOP: begin
            end
          endcase
        end
      end
      ifl_pkg::S_POP: begin
        head_nxt       = clamp_x[HW-1:0];
        count_nxt      = dec_x[HW-1:0];
        out_valid_nxt  = 1'b1;
        out_popped_nxt = head_x[ifl_pkg::SLOT_W-1:0];
        out_found_nxt  = 1'b1;
        out_err_nxt    = 1'b0;
        out_count_nxt  = dec_x[ifl_pkg::LCNT_W-1:0];
        state_nxt      = ifl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ifl_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= link_mem[head_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifl_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= HW'(POOL_SLOTS);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_popped_r <= out_popped_nxt;
    out_found_r  <= out_found_nxt;
    out_err_r    <= out_err_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD{1'b0}}, out_count_r, out_popped_r};
  assign out_tuser  = {out_err_r, out_found_r};

endmodule

### design/ifl_checker.sv
// Port-level checker for the indexed free list manager, bound to the top.
// Depends on ifl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ifl_checker #(
  parameter int POOL_SLOTS = ifl_pkg::POOL_SLOTS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ifl_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [ifl_pkg::OUT_USER_W-1:0] out_tuser
);

  logic [ifl_pkg::LCNT_W-1:0] list_count;
  logic                       in_fire;

  assign list_count = out_tdata[ifl_pkg::SLOT_W +: ifl_pkg::LCNT_W];
  assign in_fire    = in_tvalid && in_tready;

  // A pop that finds a slot is never also reported as a rejected push.
  `IFL_ASSERT(a_flags_excl, !(out_tvalid && out_tuser[0] && out_tuser[1]),
    "found and range_error both set")

  // The reported count never exceeds the pool.
  `IFL_ASSERT(a_count_bound, !out_tvalid || (32'(list_count) <= 32'(POOL_SLOTS)),
    "list count above pool size")

  // No item is taken while a result is waiting and stalled.
  `IFL_ASSERT(a_no_accept_stall, !(in_fire && out_tvalid && !out_tready),
    "item accepted while result stalled")

  // A stalled result holds its value.
  `IFL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind indexed_free_list_manager ifl_checker #(.POOL_SLOTS(POOL_SLOTS)) u_ifl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### bench/indexed_free_list_manager_tb.sv
// Self-checking testbench of indexed_free_list_manager: directed and random
// push, range push, pop and no-op items checked against an in-bench predictor.
// Depends on ifl_pkg and the indexed_free_list_manager RTL.
`timescale 1ns / 100ps

module indexed_free_list_manager_tb;

  localparam int POOL = ifl_pkg::POOL_SLOTS_DEF;

  typedef struct packed {
    logic [ifl_pkg::SLOT_W-1:0] popped;
    logic                       found;
    logic                       range_err;
    logic [ifl_pkg::LCNT_W-1:0] count;
  } slot_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ifl_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [ifl_pkg::IN_USER_W-1:0]  in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ifl_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [ifl_pkg::OUT_USER_W-1:0] out_tuser;

  // Predicted state of the free list.
  int           pool_head;
  logic [10:0]  pool_link [POOL];
  int           pool_count;
  int           last_popped;

  slot_result_t expected_results [$];
  int           mismatch_count;
  bit           idle_en;
  int           stall_left;

  indexed_free_list_manager #(.POOL_SLOTS(POOL)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void grow_count(int n);
    int room;
    room = POOL - ((pool_count > POOL) ? POOL : pool_count);
    pool_count = (n >= room) ? POOL : pool_count + n;
  endfunction

  function automatic slot_result_t free_list_step(ifl_pkg::mode_t m, int s, int c);
    slot_result_t r;
    int           nxt;
    r = '0;
    case (m)
      ifl_pkg::MODE_PUSH: begin
        if (s >= POOL) begin
          r.range_err = 1'b1;
        end else begin
          pool_link[s] = 11'(pool_head + 1);
          pool_head = s;
          grow_count(1);
        end
      end
      ifl_pkg::MODE_RANGE: begin
        if (c == 0 || s + c > POOL) begin
          r.range_err = 1'b1;
        end else begin
          pool_link[s + c - 1] = 11'(pool_head + 1);
          pool_head = s;
          grow_count(c);
        end
      end
      ifl_pkg::MODE_POP: begin
        if (pool_head < POOL) begin
          nxt = (pool_link[pool_head] != 0) ? int'(pool_link[pool_head]) - 1 : pool_head + 1;
          if (nxt > POOL) nxt = POOL;
          r.popped = ifl_pkg::SLOT_W'(pool_head);
          r.found = 1'b1;
          last_popped = pool_head;
          pool_head = nxt;
          if (pool_count > 0) pool_count--;
        end
      end
      default: ;
    endcase
    r.count = ifl_pkg::LCNT_W'(pool_count);
    return r;
  endfunction

  // Entered and left at a falling edge; in_tvalid is only lowered for a gap.
  task automatic send_item(ifl_pkg::mode_t m, int s, int c);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {3'b000, 11'(c), 10'(s)};
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    expected_results.push_back(free_list_step(m, s, c));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    slot_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("popped_slot", exp_r.popped, out_tdata[9:0]);
        check_field("list_count", exp_r.count, out_tdata[20:10]);
        check_field("found", exp_r.found, out_tuser[0]);
        check_field("range_error", exp_r.range_err, out_tuser[1]);
      end
    end
  end

  task automatic test_empty_and_nop();
    send_item(ifl_pkg::MODE_POP, 0, 0);
    send_item(ifl_pkg::MODE_NOP, 1023, 2047);
  endtask

  task automatic test_push_pop();
    send_item(ifl_pkg::MODE_PUSH, 0, 2047);
    send_item(ifl_pkg::MODE_PUSH, 1023, 0);
    send_item(ifl_pkg::MODE_POP, 1023, 2047);
    send_item(ifl_pkg::MODE_POP, 0, 0);
    send_item(ifl_pkg::MODE_POP, 0, 0);
  endtask

  task automatic test_range_errors();
    send_item(ifl_pkg::MODE_RANGE, 5, 0);
    send_item(ifl_pkg::MODE_RANGE, 1023, 2);
    send_item(ifl_pkg::MODE_RANGE, 0, 2047);
    send_item(ifl_pkg::MODE_RANGE, 1020, 4);
    send_item(ifl_pkg::MODE_POP, 0, 0);
    send_item(ifl_pkg::MODE_POP, 0, 0);
  endtask

  task automatic test_count_saturation();
    send_item(ifl_pkg::MODE_RANGE, 0, 1024);
    send_item(ifl_pkg::MODE_RANGE, 0, 1024);
    send_item(ifl_pkg::MODE_POP, 0, 0);
  endtask

  // Slot 0 still holds the end-of-list link from its earlier single push.
  task automatic test_stale_links();
    send_item(ifl_pkg::MODE_POP, 0, 0);
    send_item(ifl_pkg::MODE_POP, 0, 0);
    send_item(ifl_pkg::MODE_RANGE, 0, 3);
    send_item(ifl_pkg::MODE_POP, 0, 0);
    send_item(ifl_pkg::MODE_POP, 0, 0);
  endtask

  task automatic test_random_traffic(int n_items, bit with_idle);
    int pick;
    int s;
    int c;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) idle_en = with_idle && ($urandom_range(0, 3) != 0);
      s = $urandom_range(0, POOL - 1);
      c = $urandom_range(0, 2047);
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_item(ifl_pkg::MODE_PUSH, s, c);
      end else if (pick < 43) begin
        c = $urandom_range(1, 8);
        if (s + c > POOL) s = POOL - c;
        send_item(ifl_pkg::MODE_RANGE, s, c);
      end else if (pick < 46) begin
        send_item(ifl_pkg::MODE_RANGE, s, $urandom_range(1, POOL - s));
      end else if (pick < 53) begin
        s = (last_popped > 0) ? last_popped - 1 : 0;
        if (s + 3 > POOL) s = POOL - 3;
        send_item(ifl_pkg::MODE_RANGE, s, 3);
      end else if (pick < 58) begin
        send_item(ifl_pkg::MODE_RANGE, s, c);
      end else if (pick < 95) begin
        send_item(ifl_pkg::MODE_POP, s, c);
      end else begin
        send_item(ifl_pkg::MODE_NOP, s, c);
      end
    end
  endtask

  initial begin
    pool_head      = POOL;
    pool_count     = 0;
    last_popped    = 0;
    mismatch_count = 0;
    stall_left     = 0;
    idle_en        = 1'b0;
    foreach (pool_link[i]) pool_link[i] = '0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_en = 1'b1;
    test_empty_and_nop();
    test_push_pop();
    test_range_errors();
    test_count_saturation();
    test_stale_links();
    test_random_traffic(1500, 1'b1);
    test_random_traffic(280, 1'b0);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
